// ===== rtl/core/sdr_pkg.sv =====
// Package for the step distance dead-reckoning block: widths, codes,
// fixed-point constants and small helper functions.
// No dependencies; every other file of the block imports it.
`default_nettype none

package sdr_pkg;

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Field widths.
  localparam int IN_W    = 16;
  localparam int DIST_W  = 32;
  localparam int VEL_W   = 24;
  localparam int GAIN_W  = 16;
  localparam int THR_W   = 14;

  // Serial multiplier: product register width and rounded result width.
  localparam int PW      = 54;
  localparam int RW      = PW - 16;
  localparam int MB_W    = 20;
  localparam int CNT_W   = 5;

  // Integer square root: radicand, remainder and root widths.
  localparam int RAD_W   = 40;
  localparam int REM_W   = 23;
  localparam int ROOT_W  = 20;

  // Internal filter state widths.
  localparam int LP_W    = 21;
  localparam int GLP_W   = 28;

  // Iteration counts.
  localparam logic [CNT_W-1:0] GAIN_STEPS = CNT_W'(16);
  localparam logic [CNT_W-1:0] G_STEPS    = CNT_W'(20);
  localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(20);

  // Window length in samples before the stationary decision.
  localparam logic [2:0] WINDOW_SAMPLES = 3'd6;

  // Gravity, 9.80665 in Q.16.
  localparam logic [MB_W-1:0] G_Q16 = MB_W'(642689);

  // Half an LSB of Q.16, added before the final shift for round to nearest.
  localparam logic signed [PW-1:0] RND_INIT = PW'(32768);

  // Register reset values.
  localparam logic [GAIN_W-1:0] SAMPLE_PERIOD_RST = 16'd655;
  localparam logic [GAIN_W-1:0] ACC_LP_GAIN_RST   = 16'd8900;
  localparam logic [GAIN_W-1:0] ACC_HP_GAIN_RST   = 16'd64881;
  localparam logic [GAIN_W-1:0] GYRO_LP_GAIN_RST  = 16'd8900;
  localparam logic [THR_W-1:0]  STILL_THR_RST     = 14'd65;

  // Register indexes (byte address divided by four).
  typedef enum logic [2:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_ACC_LP_GAIN   = 3'd1,
    REG_ACC_HP_GAIN   = 3'd2,
    REG_GYRO_LP_GAIN  = 3'd3,
    REG_STILL_THR     = 3'd4
  } sdr_reg_e;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_FIN  = 4'b1000
  } sdr_state_e;

  // Which product the serial multiplier is working on.
  typedef enum logic [3:0] {
    OP_SQX,
    OP_SQY,
    OP_SQZ,
    OP_LP,
    OP_HP,
    OP_ACC,
    OP_GY,
    OP_DV,
    OP_DD
  } sdr_op_e;

  // Absolute value of a signed sample, one bit wider.
  function automatic logic [IN_W:0] abs_in(input logic signed [IN_W-1:0] a);
    logic signed [IN_W:0] ext;
    ext = (IN_W+1)'(a);
    return a[IN_W-1] ? (IN_W+1)'(-ext) : (IN_W+1)'(ext);
  endfunction

  // Saturate a rounded product to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] x);
    logic ok;
    ok = (&x[RW-1:31]) | ~(|x[RW-1:31]);
    if (ok) begin
      return x[31:0];
    end else if (x[RW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sdr_in_if.sv =====
// Sample channel of the step distance block: valid/ready plus sample fields.
// Depends on sdr_pkg for the field widths.
`default_nettype none

interface sdr_in_if;
  import sdr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic signed [IN_W-1:0] accel_x;
  logic signed [IN_W-1:0] accel_y;
  logic signed [IN_W-1:0] accel_z;
  logic signed [IN_W-1:0] gyro_rate_x;

  modport source (output valid, mode, accel_x, accel_y, accel_z, gyro_rate_x,
                  input ready);
  modport sink (input valid, mode, accel_x, accel_y, accel_z, gyro_rate_x,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sdr_out_if.sv =====
// Result channel of the step distance block: valid/ready plus result fields.
// Depends on sdr_pkg for the field widths.
`default_nettype none

interface sdr_out_if;
  import sdr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_out;
  logic [VEL_W-1:0]  velocity_out;
  logic              is_still;

  modport source (output valid, distance_out, velocity_out, is_still, input ready);
  modport sink (input valid, distance_out, velocity_out, is_still, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/step_distance_dead_reckoning.sv =====
// Step distance dead-reckoning integrator, top level.
// Depends on sdr_pkg, sdr_in_if and sdr_out_if.
//
// Usage:
//   sample_i carries one request per IMU sample (mode, accel x/y/z in Q3.12 g,
//   gyro x in Q11.4 deg/s). result_o returns one result per request:
//   distance in Q16.16 m, velocity in Q8.16 m/s and the stationary flag.
//   The APB port writes and reads the five tuning registers at 4*index;
//   pready is always high and writes are meant for when the block is idle.
//   A process request runs through one serial shift-add multiplier, one
//   multiplier bit per cycle, and a bit-pair serial square root: three
//   squares, the root, five gain products and the gravity product. The
//   result is loaded into the output register in the final state, after
//   which the block returns to idle and takes the next request.
//   A clear request (mode 1) goes straight to the final state and loads
//   its result there without using the multiplier.
//   The result sits in an output register: when the receiver stalls, the
//   block still accepts and works on the next request and only waits once
//   a second result is ready. Reset restores the register defaults and
//   zeroes all filter, window, velocity and distance state.
`default_nettype none

module step_distance_dead_reckoning (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sdr_in_if.sink                     sample_i,
  sdr_out_if.source                  result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sdr_pkg::CFG_AW-1:0] paddr,
  input  logic [sdr_pkg::CFG_DW-1:0] pwdata,
  output logic [sdr_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import sdr_pkg::*;

  // Configuration registers.
  logic [GAIN_W-1:0] sp_q, alp_q, ahp_q, glg_q;
  logic [THR_W-1:0]  thr_q;
  sdr_reg_e          reg_idx;
  logic              cfg_wr;

  // Sequencer and serial datapath.
  sdr_state_e state_q, state_d;
  sdr_op_e    op_q, op_d;
  logic signed [PW-1:0] mc_q, mc_d, pacc_q, pacc_d;
  logic [MB_W-1:0]      mb_q, mb_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [RAD_W-1:0]     rad_q, rad_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic signed [RW-1:0] accr_q, accr_d;

  // Latched sample.
  logic signed [IN_W-1:0] ay_q, az_q, gx_q;

  // Filter and integrator state.
  logic signed [LP_W-1:0]  lp_q, lp_d;
  logic signed [31:0]      hp_q, hp_d;
  logic signed [GLP_W-1:0] glp_q, glp_d;
  logic signed [31:0]      wsum_q, wsum_d;
  logic [2:0]              wcnt_q, wcnt_d;
  logic                    still_q, still_d;
  logic [VEL_W-1:0]        speed_q, speed_d;
  logic [DIST_W-1:0]       dist_q, dist_d;

  // Output register.
  logic              ov_q, ov_d;
  logic [DIST_W-1:0] od_q;
  logic [VEL_W-1:0]  ovel_q;
  logic              ost_q;
  logic              out_load;

  logic accept;

  // Register access.
  assign reg_idx = sdr_reg_e'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_SAMPLE_PERIOD: prdata = CFG_DW'(sp_q);
      REG_ACC_LP_GAIN:   prdata = CFG_DW'(alp_q);
      REG_ACC_HP_GAIN:   prdata = CFG_DW'(ahp_q);
      REG_GYRO_LP_GAIN:  prdata = CFG_DW'(glg_q);
      REG_STILL_THR:     prdata = CFG_DW'(thr_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= SAMPLE_PERIOD_RST;
      alp_q <= ACC_LP_GAIN_RST;
      ahp_q <= ACC_HP_GAIN_RST;
      glg_q <= GYRO_LP_GAIN_RST;
      thr_q <= STILL_THR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SAMPLE_PERIOD: sp_q  <= pwdata[GAIN_W-1:0];
        REG_ACC_LP_GAIN:   alp_q <= pwdata[GAIN_W-1:0];
        REG_ACC_HP_GAIN:   ahp_q <= pwdata[GAIN_W-1:0];
        REG_GYRO_LP_GAIN:  glg_q <= pwdata[GAIN_W-1:0];
        REG_STILL_THR:     thr_q <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake.
  assign sample_i.ready = (state_q == ST_IDLE);
  assign accept         = sample_i.valid & sample_i.ready;

  // Sequencer and one step of the serial datapath per cycle.
  always_comb begin
    logic signed [RW-1:0]    rnd;
    logic [IN_W:0]           a17;
    logic [REM_W-1:0]        rem_t, trial;
    logic signed [LP_W-1:0]  dl;
    logic signed [32:0]      hpin;
    logic signed [31:0]      hsat;
    logic signed [28:0]      gdiff;
    logic signed [RW:0]      v;
    logic signed [32:0]      wdiff;
    logic [32:0]             wabs;
    logic                    still_n;
    logic [VEL_W-1:0]        vcl;
    logic [DIST_W:0]         tr;

    state_d  = state_q;
    op_d     = op_q;
    mc_d     = mc_q;
    mb_d     = mb_q;
    pacc_d   = pacc_q;
    cnt_d    = cnt_q;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    accr_d   = accr_q;
    lp_d     = lp_q;
    hp_d     = hp_q;
    glp_d    = glp_q;
    wsum_d   = wsum_q;
    wcnt_d   = wcnt_q;
    still_d  = still_q;
    speed_d  = speed_q;
    dist_d   = dist_q;
    out_load = 1'b0;

    rnd     = pacc_q[PW-1:16];
    a17     = '0;
    rem_t   = '0;
    trial   = '0;
    dl      = '0;
    hpin    = '0;
    hsat    = '0;
    gdiff   = '0;
    v       = '0;
    wdiff   = '0;
    wabs    = '0;
    still_n = still_q;
    vcl     = '0;
    tr      = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sample_i.mode) begin
            // Clear request: only velocity and distance are touched.
            speed_d = '0;
            dist_d  = '0;
            state_d = ST_FIN;
          end else begin
            a17     = abs_in(sample_i.accel_x);
            mc_d    = PW'(a17);
            mb_d    = MB_W'(a17[IN_W-1:0]);
            pacc_d  = '0;
            cnt_d   = GAIN_STEPS;
            op_d    = OP_SQX;
            state_d = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        if (cnt_q != '0) begin
          // One multiplier bit per cycle, least significant first.
          if (mb_q[0]) begin
            pacc_d = pacc_q + mc_q;
          end
          mc_d  = mc_q <<< 1;
          mb_d  = mb_q >> 1;
          cnt_d = cnt_q - 1'b1;
        end else begin
          // Take the finished product and set up the next one.
          case (op_q)
            OP_SQX: begin
              a17   = abs_in(ay_q);
              mc_d  = PW'(a17);
              mb_d  = MB_W'(a17[IN_W-1:0]);
              cnt_d = GAIN_STEPS;
              op_d  = OP_SQY;
            end
            OP_SQY: begin
              a17   = abs_in(az_q);
              mc_d  = PW'(a17);
              mb_d  = MB_W'(a17[IN_W-1:0]);
              cnt_d = GAIN_STEPS;
              op_d  = OP_SQZ;
            end
            OP_SQZ: begin
              // Sum of squares scaled by 2^8 so the root comes out in Q.16.
              rad_d   = {pacc_q[31:0], 8'h00};
              rem_d   = '0;
              root_d  = '0;
              cnt_d   = ROOT_STEPS;
              state_d = ST_ROOT;
            end
            OP_LP: begin
              // The high-pass input difference equals the low-pass step.
              lp_d   = lp_q + rnd[LP_W-1:0];
              hpin   = 33'(hp_q) + rnd[32:0];
              mc_d   = PW'(hpin);
              mb_d   = MB_W'(ahp_q);
              pacc_d = RND_INIT;
              cnt_d  = GAIN_STEPS;
              op_d   = OP_HP;
            end
            OP_HP: begin
              hsat   = sat32(rnd);
              hp_d   = hsat;
              mc_d   = PW'(hsat);
              mb_d   = G_Q16;
              pacc_d = RND_INIT;
              cnt_d  = G_STEPS;
              op_d   = OP_ACC;
            end
            OP_ACC: begin
              accr_d = rnd;
              gdiff  = 29'($signed({gx_q, 12'h000})) - 29'(glp_q);
              mc_d   = PW'(gdiff);
              mb_d   = MB_W'(glg_q);
              pacc_d = RND_INIT;
              cnt_d  = GAIN_STEPS;
              op_d   = OP_GY;
            end
            OP_GY: begin
              glp_d  = glp_q + rnd[GLP_W-1:0];
              mc_d   = PW'(accr_q);
              mb_d   = MB_W'(sp_q);
              pacc_d = RND_INIT;
              cnt_d  = GAIN_STEPS;
              op_d   = OP_DV;
            end
            OP_DV: begin
              // Velocity update, window bookkeeping and stationary decision.
              v = $signed({{(RW+1-VEL_W){1'b0}}, speed_q}) + (RW+1)'(rnd);
              if (wcnt_q < WINDOW_SAMPLES) begin
                wdiff  = 33'(wsum_q) - 33'(glp_q);
                wsum_d = sat32(RW'(wdiff));
                wcnt_d = wcnt_q + 1'b1;
              end else begin
                wabs    = wsum_q[31] ? 33'(-33'(wsum_q)) : 33'(wsum_q);
                still_n = (wabs[31:16] <= {2'b00, thr_q});
                still_d = still_n;
                wsum_d  = '0;
                wcnt_d  = '0;
              end
              if (still_n || v[RW]) begin
                vcl = '0;
              end else if (|v[RW-1:VEL_W]) begin
                vcl = '1;
              end else begin
                vcl = v[VEL_W-1:0];
              end
              speed_d = vcl;
              // Distance step: twice the velocity times the period.
              mc_d    = PW'({vcl, 1'b0});
              mb_d    = MB_W'(sp_q);
              pacc_d  = RND_INIT;
              cnt_d   = GAIN_STEPS;
              op_d    = OP_DD;
            end
            OP_DD: begin
              tr      = {1'b0, dist_q} + rnd[DIST_W:0];
              dist_d  = tr[DIST_W] ? '1 : tr[DIST_W-1:0];
              state_d = ST_FIN;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end

      ST_ROOT: begin
        if (cnt_q != '0) begin
          // One root bit per cycle from two radicand bits.
          rem_t = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
          trial = {1'b0, root_q, 2'b01};
          if (rem_t >= trial) begin
            rem_d  = rem_t - trial;
            root_d = {root_q[ROOT_W-2:0], 1'b1};
          end else begin
            rem_d  = rem_t;
            root_d = {root_q[ROOT_W-2:0], 1'b0};
          end
          rad_d = rad_q << 2;
          cnt_d = cnt_q - 1'b1;
        end else begin
          dl      = $signed({1'b0, root_q}) - lp_q;
          mc_d    = PW'(dl);
          mb_d    = MB_W'(alp_q);
          pacc_d  = RND_INIT;
          cnt_d   = GAIN_STEPS;
          op_d    = OP_LP;
          state_d = ST_MUL;
        end
      end

      ST_FIN: begin
        if (!ov_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid: cleared when taken, set when a result is loaded.
  always_comb begin
    ov_d = ov_q & ~result_o.ready;
    if (out_load) begin
      ov_d = 1'b1;
    end
  end

  // Control and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SQX;
      cnt_q   <= '0;
      lp_q    <= '0;
      hp_q    <= '0;
      glp_q   <= '0;
      wsum_q  <= '0;
      wcnt_q  <= '0;
      still_q <= 1'b0;
      speed_q <= '0;
      dist_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      lp_q    <= lp_d;
      hp_q    <= hp_d;
      glp_q   <= glp_d;
      wsum_q  <= wsum_d;
      wcnt_q  <= wcnt_d;
      still_q <= still_d;
      speed_q <= speed_d;
      dist_q  <= dist_d;
      ov_q    <= ov_d;
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk_i) begin
    mc_q   <= mc_d;
    mb_q   <= mb_d;
    pacc_q <= pacc_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    accr_q <= accr_d;
    if (accept) begin
      ay_q <= sample_i.accel_y;
      az_q <= sample_i.accel_z;
      gx_q <= sample_i.gyro_rate_x;
    end
    if (out_load) begin
      od_q   <= dist_q;
      ovel_q <= speed_q;
      ost_q  <= still_q;
    end
  end

  assign result_o.valid        = ov_q;
  assign result_o.distance_out = od_q;
  assign result_o.velocity_out = ovel_q;
  assign result_o.is_still     = ost_q;

endmodule

`default_nettype wire

// ===== rtl/core/sdr_checker.sv =====
// Port-level checks for the step distance block, bound to its top level.
// Depends on sdr_pkg and on step_distance_dead_reckoning.
`default_nettype none

module sdr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [sdr_pkg::DIST_W-1:0] out_dist_i,
  input logic [sdr_pkg::VEL_W-1:0]  out_vel_i,
  input logic                       out_still_i
);
  import sdr_pkg::*;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_dist_i)
      && $stable(out_vel_i) && $stable(out_still_i))
    else $error("stalled result changed");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  // A stationary result always reports zero velocity.
  a_still_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_still_i |-> out_vel_i == '0)
    else $error("stationary result with nonzero velocity");

endmodule

bind step_distance_dead_reckoning sdr_checker u_sdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_dist_i  (result_o.distance_out),
  .out_vel_i   (result_o.velocity_out),
  .out_still_i (result_o.is_still)
);

`default_nettype wire

// ===== tb/step_distance_dead_reckoning_test.sv =====
// Self-checking testbench for the step distance dead-reckoning block.
// Depends on sdr_pkg, sdr_in_if, sdr_out_if and the block itself.
`default_nettype none

module step_distance_dead_reckoning_test;
  import sdr_pkg::*;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
  } sample_t;

  typedef struct packed {
    logic [31:0] travel;
    logic [23:0] vel;
    logic        still;
  } track_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  sdr_in_if  sample_ch ();
  sdr_out_if result_ch ();

  step_distance_dead_reckoning DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .sample_i(sample_ch.sink),
    .result_o(result_ch.source), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model copy of the tuning registers and the tracking state.
  longint unsigned period_q, lp_gain_q, hp_gain_q, gyro_gain_q, thr_q;
  longint mag_lp, mag_hp, prev_lp, gyro_lp, win_sum;
  longint unsigned speed_q, dist_q;
  int win_cnt;
  bit still_q;

  sample_t pending_samples[$];
  track_t  expected_tracks[$];
  int      sender_idle_pct = 37, receiver_idle_pct = 78, hold_cycles = 0;
  bit      failed = 1'b0;

  // Round to nearest Q16, halves toward plus infinity.
  function automatic longint rnd16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Advance the tracker by one sample and return the result it reports.
  function automatic track_t track_sample(sample_t s);
    longint ax, ay, az, gx, mag, acc, dv, v, dd, tr;
    longint unsigned sq, asum;
    track_t t;
    if (s.mode) begin
      speed_q = 0;
      dist_q = 0;
    end else begin
      ax = s.ax; ay = s.ay; az = s.az; gx = s.gx;
      sq = ax * ax + ay * ay + az * az;
      mag = int_sqrt(sq << 8);
      mag_lp += rnd16((mag - mag_lp) * longint'(lp_gain_q));
      mag_hp = clip32(rnd16((mag_hp + mag_lp - prev_lp) * longint'(hp_gain_q)));
      prev_lp = mag_lp;
      acc = rnd16(mag_hp * 642689);
      dv = rnd16(acc * longint'(period_q));
      v = longint'(speed_q) + dv;
      gyro_lp += rnd16((gx * 4096 - gyro_lp) * longint'(gyro_gain_q));
      if (win_cnt < 6) begin
        win_sum = clip32(win_sum - gyro_lp);
        win_cnt++;
      end else begin
        asum = (win_sum < 0) ? -win_sum : win_sum;
        still_q = ((asum >> 16) <= thr_q);
        win_sum = 0;
        win_cnt = 0;
      end
      if (still_q) v = 0;
      if (v < 0) v = 0;
      if (v > 16777215) v = 16777215;
      speed_q = v;
      dd = rnd16(v * longint'(period_q) * 2);
      tr = longint'(dist_q) + dd;
      if (tr > 64'sd4294967295) tr = 64'sd4294967295;
      dist_q = tr;
    end
    t.travel = dist_q[31:0];
    t.vel = speed_q[23:0];
    t.still = still_q;
    return t;
  endfunction

  // Sender: offers queued samples, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
      sample_ch.mode <= 1'b0;
      sample_ch.accel_x <= '0;
      sample_ch.accel_y <= '0;
      sample_ch.accel_z <= '0;
      sample_ch.gyro_rate_x <= '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_tracks.push_back(track_sample({sample_ch.mode, sample_ch.accel_x,
          sample_ch.accel_y, sample_ch.accel_z, sample_ch.gyro_rate_x}));
        void'(pending_samples.pop_front());
      end
      if (((sample_ch.valid && sample_ch.ready) || !sample_ch.valid)) begin
        if (pending_samples.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
          sample_ch.valid <= 1'b1;
          {sample_ch.mode, sample_ch.accel_x, sample_ch.accel_y, sample_ch.accel_z,
           sample_ch.gyro_rate_x} <= pending_samples[0];
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Checker: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    track_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_tracks.size() == 0) begin
        $error("unexpected result distance_out=%0d velocity_out=%0d",
               result_ch.distance_out, result_ch.velocity_out);
        failed = 1'b1;
      end else begin
        want = expected_tracks.pop_front();
        if (result_ch.distance_out !== want.travel) begin
          $error("distance_out expected %0d got %0d", want.travel, result_ch.distance_out);
          failed = 1'b1;
        end
        if (result_ch.velocity_out !== want.vel) begin
          $error("velocity_out expected %0d got %0d", want.vel, result_ch.velocity_out);
          failed = 1'b1;
        end
        if (result_ch.is_still !== want.still) begin
          $error("is_still expected %0d got %0d", want.still, result_ch.is_still);
          failed = 1'b1;
        end
      end
    end
  end

  // Register write over the APB-style port; the model copy follows.
  task automatic write_reg(sdr_reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SAMPLE_PERIOD: period_q = value[15:0];
      REG_ACC_LP_GAIN:   lp_gain_q = value[15:0];
      REG_ACC_HP_GAIN:   hp_gain_q = value[15:0];
      REG_GYRO_LP_GAIN:  gyro_gain_q = value[15:0];
      default:           thr_q = value[13:0];
    endcase
  endtask

  task automatic set_regs(logic [15:0] p, logic [15:0] lp, logic [15:0] hp,
                          logic [15:0] gy, logic [13:0] th);
    write_reg(REG_SAMPLE_PERIOD, 32'(p));
    write_reg(REG_ACC_LP_GAIN, 32'(lp));
    write_reg(REG_ACC_HP_GAIN, 32'(hp));
    write_reg(REG_GYRO_LP_GAIN, 32'(gy));
    write_reg(REG_STILL_THR, 32'(th));
  endtask

  // Wait until every queued request has gone through and every result arrived.
  task automatic drain();
    while (pending_samples.size() != 0 || expected_tracks.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic sample_t walk_sample();
    sample_t s;
    s.mode = ($urandom_range(49) == 0);
    s.ax = $signed(16'($urandom_range(2000))) - 16'sd1000;
    s.ay = $signed(16'($urandom_range(2000))) - 16'sd1000;
    s.az = 16'sd4096 + $signed(16'($urandom_range(3000))) - 16'sd1500;
    s.gx = $signed(16'($urandom_range(1200))) - 16'sd600;
    if ($urandom_range(9) == 0) s = {1'b0, 64'($urandom) << 32 | 64'($urandom)};
    return s;
  endfunction

  task automatic random_phase(int count, int sidle, int ridle);
    sender_idle_pct = sidle;
    receiver_idle_pct = ridle;
    repeat (count) pending_samples.push_back(walk_sample());
    drain();
  endtask

  initial begin
    period_q = 655; lp_gain_q = 8900; hp_gain_q = 64881;
    gyro_gain_q = 8900; thr_q = 65;
    mag_lp = 0; mag_hp = 0; prev_lp = 0; gyro_lp = 0; win_sum = 0;
    speed_q = 0; dist_q = 0; win_cnt = 0; still_q = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, clears, window decisions, saturation.
    pending_samples.push_back({1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    pending_samples.push_back({1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    pending_samples.push_back({1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
    pending_samples.push_back({1'b1, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh7FFF});
    for (int i = 0; i < 8; i++)
      pending_samples.push_back({1'b0, 16'sh0000, 16'sh0000, 16'sh1000, 16'sh0000});
    for (int i = 0; i < 8; i++)
      pending_samples.push_back({1'b0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
    drain();

    // Zero period, fast filters, extreme threshold.
    set_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
    random_phase(40, 37, 78);
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 14'd0);
    for (int i = 0; i < 20; i++)
      pending_samples.push_back({1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh0000});
    random_phase(30, 37, 78);
    set_regs(16'd1, 16'd0, 16'd0, 16'hFFFF, 14'd0);
    random_phase(40, 37, 78);

    // Back to defaults, then the idling phases.
    set_regs(16'd655, 16'd8900, 16'd64881, 16'd8900, 14'd65);
    random_phase(220, 37, 78);
    random_phase(220, 78, 37);

    // Long hold-off while the sender keeps offering requests.
    hold_cycles = 2000;
    random_phase(40, 0, 0);
    set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             14'($urandom_range(200)));
    random_phase(200, 0, 0);

    if (!failed) begin
      $display("step_distance_dead_reckoning_test OK");
    end else begin
      $display("step_distance_dead_reckoning_test NOT OK");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #4000000;
    $display("step_distance_dead_reckoning_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
